@@ sv/rlms_pkg.sv @@
// ----------------------------------------------------------------------------
// rlms_pkg: shared types and constants for the RGB LED matrix scan driver
// Opcodes, colour phases, register indexes and the structs passed between
// the frame buffer, the scan sequencer and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package rlms_pkg;

  localparam int unsigned BUF_ROWS  = 8;   // rows held in the frame buffer
  localparam int unsigned COL_W     = 3;
  localparam int unsigned ROW_W     = 3;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ROW_BITS  = 24;  // red, green, blue bytes
  localparam int unsigned DWELL_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [ROW_BITS-1:0] ROW_OFF   = '1;   // every LED dark
  localparam logic [BYTE_W-1:0]   BYTE_OFF  = 8'hFF;

  localparam logic [DWELL_W-1:0]  RED_DWELL_RST   = 16'd100;
  localparam logic [DWELL_W-1:0]  GREEN_DWELL_RST = 16'd70;
  localparam logic [DWELL_W-1:0]  BLUE_DWELL_RST  = 16'd60;

  // bit positions of the three colour bytes within a buffer row
  localparam int unsigned RED_BASE   = 16;
  localparam int unsigned GREEN_BASE = 8;
  localparam int unsigned BLUE_BASE  = 0;

  typedef enum logic [1:0] {
    OP_SET_PIXEL = 2'd0,
    OP_CLEAR     = 2'd1,
    OP_TICK      = 2'd2
  } rlms_op_t;

  typedef enum logic [1:0] {
    PHASE_RED   = 2'd0,
    PHASE_BLUE  = 2'd1,
    PHASE_GREEN = 2'd2
  } rlms_phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RED_DWELL   = 2'd0,
    REG_GREEN_DWELL = 2'd1,
    REG_BLUE_DWELL  = 2'd2
  } rlms_reg_t;

  // buffer update command
  typedef struct packed {
    logic             set_en;
    logic             clear;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             red_on;
    logic             green_on;
    logic             blue_on;
  } rlms_wr_t;

  // one emitted frame
  typedef struct packed {
    logic [BYTE_W-1:0] red_byte;
    logic [BYTE_W-1:0] blue_byte;
    logic [BYTE_W-1:0] green_byte;
    logic [BYTE_W-1:0] row_select;
    logic [ROW_W-1:0]  row_idx;
    logic [1:0]        phase;
  } rlms_frame_t;

endpackage

`default_nettype wire

@@ sv/rlms_frame_buf.sv @@
// ----------------------------------------------------------------------------
// rlms_frame_buf: 8-row active-low colour frame buffer
// Single pixel writes, whole-buffer clear, one read port at the scan row.
// ----------------------------------------------------------------------------
`default_nettype none

module rlms_frame_buf (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire rlms_pkg::rlms_wr_t              wr,
  input  wire logic [rlms_pkg::ROW_W-1:0]      rd_row,
  output logic      [rlms_pkg::ROW_BITS-1:0]   rd_data
);
  import rlms_pkg::*;

  logic [ROW_BITS-1:0] rows_r   [BUF_ROWS];
  logic [ROW_BITS-1:0] row_upd;

  // patch the three colour bits of the addressed pixel; 0 lights the LED
  always_comb begin
    row_upd = rows_r[wr.row];
    row_upd[RED_BASE   + 32'(wr.col)] = ~wr.red_on;
    row_upd[GREEN_BASE + 32'(wr.col)] = ~wr.green_on;
    row_upd[BLUE_BASE  + 32'(wr.col)] = ~wr.blue_on;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || wr.clear) begin
      for (int i = 0; i < BUF_ROWS; i++) begin
        rows_r[i] <= ROW_OFF;
      end
    end else if (wr.set_en) begin
      rows_r[wr.row] <= row_upd;
    end
  end

  assign rd_data = rows_r[rd_row];

endmodule

`default_nettype wire

@@ sv/rlms_scan.sv @@
// ----------------------------------------------------------------------------
// rlms_scan: row and colour phase sequencer with dwell timer
// Holds the dwell registers, steps red, blue, green per row on ticks.
// ----------------------------------------------------------------------------
`default_nettype none

module rlms_scan #(
  parameter int unsigned ROW_COUNT = 8
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [rlms_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  wire logic [rlms_pkg::DWELL_W-1:0]     cfg_val,
  input  wire logic                             tick,
  input  wire logic [rlms_pkg::ROW_BITS-1:0]    row_data,
  output logic      [rlms_pkg::ROW_W-1:0]       scan_row,
  output logic                                  emit,
  output rlms_pkg::rlms_frame_t                 frame
);
  import rlms_pkg::*;

  logic [DWELL_W-1:0] red_dwell_r, green_dwell_r, blue_dwell_r;
  logic [ROW_W-1:0]   row_r, row_nxt;
  rlms_phase_t        phase_r, phase_nxt;
  logic [DWELL_W-1:0] dwell_r, dwell_nxt, dwell_base, dwell_load;
  logic [ROW_W:0]     row_inc;

  assign emit     = tick && (dwell_r == '0);
  assign scan_row = row_r;
  assign row_inc  = {1'b0, row_r} + (ROW_W+1)'(1);

  always_comb begin
    frame.red_byte   = BYTE_OFF;
    frame.blue_byte  = BYTE_OFF;
    frame.green_byte = BYTE_OFF;
    frame.row_select = BYTE_W'(1) << row_r;
    frame.row_idx    = row_r;
    frame.phase      = phase_r;
    row_nxt          = row_r;
    phase_nxt        = phase_r;
    case (phase_r)
      PHASE_RED: begin
        frame.red_byte = row_data[RED_BASE +: BYTE_W];
        dwell_load     = red_dwell_r;
        phase_nxt      = PHASE_BLUE;
      end
      PHASE_BLUE: begin
        frame.blue_byte = row_data[BLUE_BASE +: BYTE_W];
        dwell_load      = blue_dwell_r;
        phase_nxt       = PHASE_GREEN;
      end
      default: begin
        frame.green_byte = row_data[GREEN_BASE +: BYTE_W];
        dwell_load       = green_dwell_r;
        phase_nxt        = PHASE_RED;
        // wrap after the last scanned row
        row_nxt = (row_inc >= (ROW_W+1)'(ROW_COUNT)) ? '0 : row_inc[ROW_W-1:0];
      end
    endcase
    dwell_base = emit ? dwell_load : dwell_r;
    dwell_nxt  = (dwell_base == '0) ? '0 : dwell_base - DWELL_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_dwell_r   <= RED_DWELL_RST;
      green_dwell_r <= GREEN_DWELL_RST;
      blue_dwell_r  <= BLUE_DWELL_RST;
      row_r         <= '0;
      phase_r       <= PHASE_RED;
      dwell_r       <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_RED_DWELL:   red_dwell_r   <= cfg_val;
          REG_GREEN_DWELL: green_dwell_r <= cfg_val;
          REG_BLUE_DWELL:  blue_dwell_r  <= cfg_val;
          default: ;
        endcase
      end
      if (tick) begin
        dwell_r <= dwell_nxt;
        if (emit) begin
          row_r   <= row_nxt;
          phase_r <= phase_nxt;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ sv/rgb_led_matrix_scan_driver_core.sv @@
// ----------------------------------------------------------------------------
// rgb_led_matrix_scan_driver_core: scan driver for a common-anode RGB matrix
// Frame buffer, phase sequencer and frame output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one command word per cycle unless
//   stalled: set pixel, clear screen or a one-microsecond tick. Set pixel and clear
//   only update the frame buffer and produce no output. A tick whose dwell
//   count has run out emits one frame word on the output channel
//   (out_valid / out_stall): red, blue and green column bytes (255 for the
//   two colours not in phase), the one-hot row select, the row index and the
//   colour phase; the dwell counter is then reloaded for that colour.
//   An accepted word is registered in the input register and its frame, if
//   any, then in the output register. Throughput: one word per cycle unless
//   stalled, set by the single input register feeding the output register.
//   Stall: while a frame waits under out_stall, the next word waits in the
//   input register and in_stall rises; the buffer and scan state then hold.
//   Configuration (cfg_valid / cfg_ready, always ready) sets the red, green
//   and blue dwell registers; write only while the block is idle.
//   Reset (rst_n, synchronous): buffer all dark, scan at row 0 red, dwell
//   count zero, dwell registers 100 / 70 / 60, both channels empty.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_led_matrix_scan_driver_core #(
  parameter int unsigned ROW_COUNT = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command words
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [1:0]                      in_opcode,
  input  wire logic [rlms_pkg::COL_W-1:0]      in_pixel_column,
  input  wire logic [rlms_pkg::ROW_W-1:0]      in_pixel_row,
  input  wire logic                            in_red_on,
  input  wire logic                            in_green_on,
  input  wire logic                            in_blue_on,
  // frame words
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic      [rlms_pkg::BYTE_W-1:0]     out_red_byte,
  output logic      [rlms_pkg::BYTE_W-1:0]     out_blue_byte,
  output logic      [rlms_pkg::BYTE_W-1:0]     out_green_byte,
  output logic      [rlms_pkg::BYTE_W-1:0]     out_row_select,
  output logic      [rlms_pkg::ROW_W-1:0]      out_scan_row_index,
  output logic      [1:0]                      out_color_phase,
  // configuration
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [rlms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlms_pkg::DWELL_W-1:0]    cfg_data
);
  import rlms_pkg::*;

  // input register
  logic             in_vld_r;
  logic [1:0]       op_r;
  logic [COL_W-1:0] col_r;
  logic [ROW_W-1:0] row_r;
  logic             red_r, green_r, blue_r;

  // output register
  logic        out_vld_r;
  rlms_frame_t out_r;

  logic                fire;      // registered word is processed this cycle
  logic                advance;   // output register free to load
  rlms_wr_t            wr;
  logic [ROW_W-1:0]    scan_row;
  logic [ROW_BITS-1:0] scan_data;
  logic                emit;
  rlms_frame_t         frame;

  assign advance  = !out_vld_r || !out_stall;
  assign fire     = in_vld_r && advance;
  assign in_stall = in_vld_r && !advance;
  assign cfg_ready = 1'b1;

  // decode the held word into a buffer command; unused opcode does nothing
  always_comb begin
    wr.set_en   = fire && (op_r == OP_SET_PIXEL);
    wr.clear    = fire && (op_r == OP_CLEAR);
    wr.row      = row_r;
    wr.col      = col_r;
    wr.red_on   = red_r;
    wr.green_on = green_r;
    wr.blue_on  = blue_r;
  end

  rlms_frame_buf u_buf (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_row  (scan_row),
    .rd_data (scan_data)
  );

  rlms_scan #(
    .ROW_COUNT (ROW_COUNT)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_idx  (cfg_index),
    .cfg_val  (cfg_data),
    .tick     (fire && (op_r == OP_TICK)),
    .row_data (scan_data),
    .scan_row (scan_row),
    .emit     (emit),
    .frame    (frame)
  );

  // capture a new word whenever the register is empty or drains this cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_opcode;
      col_r   <= in_pixel_column;
      row_r   <= in_pixel_row;
      red_r   <= in_red_on;
      green_r <= in_green_on;
      blue_r  <= in_blue_on;
    end
  end

  // hold the frame while the receiver stalls, otherwise load or drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= fire && emit;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      out_r <= frame;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_red_byte       = out_r.red_byte;
  assign out_blue_byte      = out_r.blue_byte;
  assign out_green_byte     = out_r.green_byte;
  assign out_row_select     = out_r.row_select;
  assign out_scan_row_index = out_r.row_idx;
  assign out_color_phase    = out_r.phase;

endmodule

`default_nettype wire

@@ verif/scan_frame_checker.sv @@
// ----------------------------------------------------------------------------
// scan_frame_checker: frame predictor and scoreboard for the matrix scan driver
// Watches the command, frame and register channels, keeps its own copy of the
// frame buffer, scan position and dwell counter, and compares every frame
// word leaving the block with the oldest predicted frame.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_frame_checker #(
  parameter int unsigned ROW_COUNT = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  input  wire logic                            in_stall,
  input  wire logic [1:0]                      in_opcode,
  input  wire logic [rlms_pkg::COL_W-1:0]      in_pixel_column,
  input  wire logic [rlms_pkg::ROW_W-1:0]      in_pixel_row,
  input  wire logic                            in_red_on,
  input  wire logic                            in_green_on,
  input  wire logic                            in_blue_on,
  input  wire logic                            out_valid,
  input  wire logic                            out_stall,
  input  wire logic [rlms_pkg::BYTE_W-1:0]     out_red_byte,
  input  wire logic [rlms_pkg::BYTE_W-1:0]     out_blue_byte,
  input  wire logic [rlms_pkg::BYTE_W-1:0]     out_green_byte,
  input  wire logic [rlms_pkg::BYTE_W-1:0]     out_row_select,
  input  wire logic [rlms_pkg::ROW_W-1:0]      out_scan_row_index,
  input  wire logic [1:0]                      out_color_phase,
  input  wire logic                            cfg_valid,
  input  wire logic                            cfg_ready,
  input  wire logic [rlms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [rlms_pkg::DWELL_W-1:0]    cfg_data,
  output int                                   error_count,
  output int                                   frames_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import rlms_pkg::*;

  logic [ROW_BITS-1:0] shadow_rows [BUF_ROWS];
  logic [ROW_W-1:0]    scan_row;
  rlms_phase_t         scan_phase;
  logic [DWELL_W-1:0]  dwell_left;
  logic [DWELL_W-1:0]  red_dwell, green_dwell, blue_dwell;
  rlms_frame_t         frames_due [$];

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Apply one accepted command word to the shadow state; queue a frame if due.
  task automatic apply_word(input logic [1:0] op, input logic [COL_W-1:0] col,
                            input logic [ROW_W-1:0] row, input logic red_on,
                            input logic green_on, input logic blue_on);
    logic [ROW_BITS-1:0] line;
    rlms_frame_t         frame;
    case (op)
      OP_SET_PIXEL: begin
        line                    = shadow_rows[row];
        line[RED_BASE + col]    = ~red_on;
        line[GREEN_BASE + col]  = ~green_on;
        line[BLUE_BASE + col]   = ~blue_on;
        shadow_rows[row]        = line;
      end
      OP_CLEAR: begin
        foreach (shadow_rows[i]) shadow_rows[i] = ROW_OFF;
      end
      OP_TICK: begin
        if (dwell_left == '0) begin
          line             = shadow_rows[scan_row];
          frame.red_byte   = BYTE_OFF;
          frame.blue_byte  = BYTE_OFF;
          frame.green_byte = BYTE_OFF;
          case (scan_phase)
            PHASE_RED: begin
              frame.red_byte = line[RED_BASE +: BYTE_W];
              dwell_left     = red_dwell;
            end
            PHASE_BLUE: begin
              frame.blue_byte = line[BLUE_BASE +: BYTE_W];
              dwell_left      = blue_dwell;
            end
            default: begin
              frame.green_byte = line[GREEN_BASE +: BYTE_W];
              dwell_left       = green_dwell;
            end
          endcase
          frame.row_select           = '0;
          frame.row_select[scan_row] = 1'b1;
          frame.row_idx              = scan_row;
          frame.phase                = scan_phase;
          frames_due.push_back(frame);
          // advance red -> blue -> green -> next row
          if (scan_phase == PHASE_RED) begin
            scan_phase = PHASE_BLUE;
          end else if (scan_phase == PHASE_BLUE) begin
            scan_phase = PHASE_GREEN;
          end else begin
            scan_phase = PHASE_RED;
            scan_row   = (scan_row == ROW_W'(ROW_COUNT - 1)) ? '0 : scan_row + 1'b1;
          end
        end
        if (dwell_left != '0) dwell_left = dwell_left - 1'b1;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    rlms_frame_t want;
    if (!rst_n) begin
      foreach (shadow_rows[i]) shadow_rows[i] = ROW_OFF;
      scan_row    = '0;
      scan_phase  = PHASE_RED;
      dwell_left  = '0;
      red_dwell   = RED_DWELL_RST;
      green_dwell = GREEN_DWELL_RST;
      blue_dwell  = BLUE_DWELL_RST;
      error_count = 0;
      frames_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame word, expected none, actual row %0d phase %0d",
                   $time, out_scan_row_index, out_color_phase);
          error_count++;
        end else begin
          want = frames_due.pop_front();
          check_field("red_byte",       32'(want.red_byte),   32'(out_red_byte));
          check_field("blue_byte",      32'(want.blue_byte),  32'(out_blue_byte));
          check_field("green_byte",     32'(want.green_byte), 32'(out_green_byte));
          check_field("row_select",     32'(want.row_select), 32'(out_row_select));
          check_field("scan_row_index", 32'(want.row_idx),    32'(out_scan_row_index));
          check_field("color_phase",    32'(want.phase),      32'(out_color_phase));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_RED_DWELL:   red_dwell   = cfg_data;
          REG_GREEN_DWELL: green_dwell = cfg_data;
          REG_BLUE_DWELL:  blue_dwell  = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        apply_word(in_opcode, in_pixel_column, in_pixel_row,
                   in_red_on, in_green_on, in_blue_on);
    end
    frames_pending = frames_due.size();
  end

endmodule

`default_nettype wire

@@ verif/tb.sv @@
// ----------------------------------------------------------------------------
// tb: top-level testbench for the RGB LED matrix scan driver
// Drives pixel writes, clears, ticks and dwell register writes with random
// idling on both channels; the checker beside the block predicts each frame
// word and counts mismatches, and this module gives the verdict.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rlms_pkg::*;

  // codes the package leaves unnamed: both must be ignored by the block
  localparam logic [1:0]           OP_UNUSED    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 2'd3;

  localparam int unsigned ROW_COUNT     = 8;
  localparam int          SETTLE_CYCLES = 4;     // lets a word in flight drain
  localparam int          STALL_LIMIT   = 2000;  // cycles without any handshake

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_opcode       = OP_TICK;
  logic [COL_W-1:0]     in_pixel_column = '0;
  logic [ROW_W-1:0]     in_pixel_row    = '0;
  logic                 in_red_on       = 1'b0;
  logic                 in_green_on     = 1'b0;
  logic                 in_blue_on      = 1'b0;

  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [BYTE_W-1:0]    out_red_byte;
  logic [BYTE_W-1:0]    out_blue_byte;
  logic [BYTE_W-1:0]    out_green_byte;
  logic [BYTE_W-1:0]    out_row_select;
  logic [ROW_W-1:0]     out_scan_row_index;
  logic [1:0]           out_color_phase;

  logic                 cfg_valid       = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index       = '0;
  logic [DWELL_W-1:0]   cfg_data        = '0;

  int error_count;
  int frames_pending;

  // idling odds in percent, changed phase by phase
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int stall_left    = 0;
  int quiet_cycles  = 0;

  always #5 clk = ~clk;

  rgb_led_matrix_scan_driver_core #(
    .ROW_COUNT (ROW_COUNT)
  ) u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_pixel_column    (in_pixel_column),
    .in_pixel_row       (in_pixel_row),
    .in_red_on          (in_red_on),
    .in_green_on        (in_green_on),
    .in_blue_on         (in_blue_on),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_red_byte       (out_red_byte),
    .out_blue_byte      (out_blue_byte),
    .out_green_byte     (out_green_byte),
    .out_row_select     (out_row_select),
    .out_scan_row_index (out_scan_row_index),
    .out_color_phase    (out_color_phase),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  scan_frame_checker #(
    .ROW_COUNT (ROW_COUNT)
  ) u_chk (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_opcode          (in_opcode),
    .in_pixel_column    (in_pixel_column),
    .in_pixel_row       (in_pixel_row),
    .in_red_on          (in_red_on),
    .in_green_on        (in_green_on),
    .in_blue_on         (in_blue_on),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_red_byte       (out_red_byte),
    .out_blue_byte      (out_blue_byte),
    .out_green_byte     (out_green_byte),
    .out_row_select     (out_row_select),
    .out_scan_row_index (out_scan_row_index),
    .out_color_phase    (out_color_phase),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .error_count        (error_count),
    .frames_pending     (frames_pending)
  );

  // Frame side back-pressure: hold out_stall for bursts of random length.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (out_stall_pct != 0 && $urandom_range(99) < out_stall_pct) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(9);
    end else begin
      out_stall  <= 1'b0;
    end
  end

  // Watchdog: any handshake on any channel counts as progress.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Present one command word and hold it until the block takes it. Returns on
  // the accepting edge with in_valid still high, so the next word follows on.
  task automatic send_word(input logic [1:0] op, input logic [COL_W-1:0] col,
                           input logic [ROW_W-1:0] row, input logic red_on,
                           input logic green_on, input logic blue_on);
    if (in_gap_pct != 0 && $urandom_range(99) < in_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_pixel_column <= col;
    in_pixel_row    <= row;
    in_red_on       <= red_on;
    in_green_on     <= green_on;
    in_blue_on      <= blue_on;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_ticks(input int count);
    repeat (count) send_word(OP_TICK, '0, '0, 1'b0, 1'b0, 1'b0);
  endtask

  // Drop valid and wait until every predicted frame has left, then let a word
  // with no frame drain from the pipeline before touching the registers.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (frames_pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DWELL_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_dwells(input logic [DWELL_W-1:0] red, input logic [DWELL_W-1:0] green,
                            input logic [DWELL_W-1:0] blue);
    write_reg(REG_RED_DWELL,   red);
    write_reg(REG_GREEN_DWELL, green);
    write_reg(REG_BLUE_DWELL,  blue);
  endtask

  // Pick fresh idling odds; zero on one side or both gives stretches at full rate.
  task automatic pick_idling();
    int odds [3] = '{0, 20, 50};
    in_gap_pct    = odds[$urandom_range(2)];
    out_stall_pct = odds[$urandom_range(2)];
  endtask

  // Mostly ticks and pixel writes with random content, a few clears and
  // unused opcodes sprinkled through.
  task automatic random_words(input int count);
    int         pick;
    logic [1:0] op;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 55)      op = OP_TICK;
      else if (pick < 92) op = OP_SET_PIXEL;
      else if (pick < 95) op = OP_CLEAR;
      else                op = OP_UNUSED;
      send_word(op, COL_W'($urandom), ROW_W'($urandom), 1'($urandom),
                1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    // hold reset, then release
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under the reset dwells: pixel extremes, set then unset,
    // an unused opcode with every field high, then the first tick.
    send_word(OP_SET_PIXEL, 3'd0, 3'd0, 1'b1, 1'b0, 1'b1);
    send_word(OP_SET_PIXEL, 3'd7, 3'd0, 1'b1, 1'b1, 1'b1);
    send_word(OP_SET_PIXEL, 3'd7, 3'd7, 1'b0, 1'b1, 1'b0);
    send_word(OP_SET_PIXEL, 3'd3, 3'd5, 1'b1, 1'b1, 1'b1);
    send_word(OP_SET_PIXEL, 3'd3, 3'd5, 1'b0, 1'b0, 1'b0);
    send_word(OP_UNUSED,    3'd7, 3'd7, 1'b1, 1'b1, 1'b1);
    send_ticks(1);
    // clear, repaint, and tick through the whole red dwell to the blue frame
    send_word(OP_CLEAR,     3'd0, 3'd0, 1'b0, 1'b0, 1'b0);
    send_word(OP_SET_PIXEL, 3'd1, 3'd0, 1'b1, 1'b1, 1'b0);
    send_ticks(100);
    wait_idle();

    // Zero dwell: each tick emits a frame. The unmapped index must be dropped.
    set_dwells('0, '0, '0);
    write_reg(REG_UNMAPPED, '1);
    for (int r = 0; r < ROW_COUNT; r++)
      send_word(OP_SET_PIXEL, COL_W'(r), ROW_W'(r), r[0], r[1], r[2]);
    // drain the blue dwell still running, then walk every row and phase
    send_ticks(60 + 3 * ROW_COUNT);
    wait_idle();

    // Random phases under a spread of small dwell settings.
    pick_idling();
    set_dwells(16'd1, 16'd2, 16'd3);
    random_words(40);
    for (int p = 0; p < 3; p++) begin
      wait_idle();
      pick_idling();
      set_dwells(DWELL_W'($urandom_range(4)), DWELL_W'($urandom_range(4)),
                 DWELL_W'($urandom_range(4)));
      random_words(40);
    end
    wait_idle();
    pick_idling();
    set_dwells('0, '0, '0);
    random_words(40);

    // Last part, no idling: largest dwell on every colour, one frame and
    // then the first steps of the long count-down.
    in_gap_pct    = 0;
    out_stall_pct = 0;
    wait_idle();
    while (out_stall) @(posedge clk);
    set_dwells('1, '1, '1);
    send_ticks(8);

    // Wait for the last frames, then a few more edges for anything stray.
    in_valid <= 1'b0;
    @(negedge clk);
    while (frames_pending != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

endmodule

`default_nettype wire
